// ===== hw/rtl/radar_measurement_jacobian_top_macros.svh =====
// Assertion macros for the radar measurement Jacobian block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef RADAR_MEASUREMENT_JACOBIAN_TOP_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RMJ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rmj_pkg.sv =====
// Shared types, constants and step functions of the radar Jacobian block.
// No dependencies; imported by rmj_front, rmj_cell and the top level.
`timescale 1ns / 1ps

package rmj_pkg;

	localparam int FRAC_BITS   = 16;
	// left-aligned numerator field, wide enough for the range-rate numerator
	localparam int NUM_W       = 96 + FRAC_BITS;
	localparam int SQRT_STEPS  = 32;
	localparam int RANGE_STEPS = 32 + FRAC_BITS;
	localparam int BRG_STEPS   = 32 + 2 * FRAC_BITS;
	localparam int RATE1_STEPS = NUM_W;
	localparam int RATE2_STEPS = 64;
	localparam int N_CELLS     = RATE1_STEPS + RATE2_STEPS;
	localparam int IDX_W       = $clog2(N_CELLS);
	localparam int N_LANES     = 8;

	localparam logic [IDX_W-1:0] SQRT_END  = IDX_W'(SQRT_STEPS);
	localparam logic [IDX_W-1:0] RANGE_END = IDX_W'(SQRT_STEPS + RANGE_STEPS);
	localparam logic [IDX_W-1:0] BRG_END   = IDX_W'(BRG_STEPS);
	localparam logic [IDX_W-1:0] RATE1_END = IDX_W'(RATE1_STEPS);

	typedef enum logic {
		REG_THRESH,
		REG_FLOOR
	} cfg_reg_e;

	typedef enum logic [2:0] {
		LN_RANGE_DX,
		LN_RANGE_DY,
		LN_BRG_DX,
		LN_BRG_DY,
		LN_R1_DX,
		LN_R1_DY,
		LN_R2_DX,
		LN_R2_DY
	} lane_e;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [63:0]      rem;
		logic [63:0]      q;
		logic             ovf;
	} div_t;

	typedef struct packed {
		logic [63:0] v;
		logic [35:0] rem;
		logic [31:0] res;
	} sqrt_t;

	typedef struct packed {
		div_t [N_LANES-1:0] lane;
		sqrt_t              sq;
		logic [63:0]        r2;
		logic               sx;
		logic               sy;
		logic               sd;
		logic               degen;
	} cell_st_t;

	typedef struct packed {
		logic [31:0] range_dx;
		logic [31:0] range_dy;
		logic [31:0] bearing_dx;
		logic [31:0] bearing_dy;
		logic [31:0] rate_dx;
		logic [31:0] rate_dy;
		logic        degenerate;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic [31:0] val;
		logic        clip;
	} sat_t;

	// one restoring division step: shift in the top numerator bit
	function automatic div_t div_step(div_t s, logic [63:0] d);
		logic [64:0] sh;
		logic        qb;
		div_t        r;
		r  = s;
		sh = {s.rem, s.num[NUM_W-1]};
		qb = (sh >= {1'b0, d});
		if (qb) begin
			r.rem = sh[63:0] - d;
		end else begin
			r.rem = sh[63:0];
		end
		r.ovf = s.ovf | s.q[63];
		r.q   = {s.q[62:0], qb};
		r.num = {s.num[NUM_W-2:0], 1'b0};
		return r;
	endfunction

	// one digit of the floor square root, two radicand bits per step
	function automatic sqrt_t sqrt_step(sqrt_t s);
		logic [35:0] sh;
		logic [35:0] trial;
		sqrt_t       r;
		sh    = {s.rem[33:0], s.v[63:62]};
		trial = {2'b00, s.res, 2'b01};
		r.v   = {s.v[61:0], 2'b00};
		if (sh >= trial) begin
			r.rem = sh - trial;
			r.res = {s.res[30:0], 1'b1};
		end else begin
			r.rem = sh;
			r.res = {s.res[30:0], 1'b0};
		end
		return r;
	endfunction

	// quotient clamped to 64 bits
	function automatic logic [63:0] q_clamp(div_t s);
		return s.ovf ? {64{1'b1}} : s.q;
	endfunction

	// clip a sign-magnitude value to signed 32 bits
	function automatic sat_t sat32(logic neg, logic [63:0] q, logic ovf);
		logic [63:0] lim;
		logic [31:0] mag;
		sat_t        r;
		lim    = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
		r.clip = ovf | (q > lim);
		mag    = r.clip ? lim[31:0] : q[31:0];
		r.val  = neg ? (~mag + 32'd1) : mag;
		return r;
	endfunction

endpackage

// ===== hw/rtl/rmj_front.sv =====
// Front end: sign split, products, r squared with degenerate check, cell load.
// Depends on rmj_pkg; feeds the first cell of the chain.
`timescale 1ns / 1ps

module rmj_front import rmj_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic        cfg_we,
	input  cfg_reg_e    cfg_idx,
	input  logic [31:0] cfg_data,
	output logic        v_out,
	output cell_st_t    st_out
);

	logic [31:0] thresh_q, floor_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 32'd43;
			floor_q  <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESH: thresh_q <= cfg_data;
				REG_FLOOR:  floor_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// valid bits move with the chain enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: sign and magnitude
	logic        sx_s1, sy_s1, svx_s1, svy_s1;
	logic [31:0] mx_s1, my_s1, mvx_s1, mvy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= pos_x[31];
			sy_s1  <= pos_y[31];
			svx_s1 <= vel_x[31];
			svy_s1 <= vel_y[31];
			mx_s1  <= pos_x[31] ? (~pos_x + 32'd1) : pos_x;
			my_s1  <= pos_y[31] ? (~pos_y + 32'd1) : pos_y;
			mvx_s1 <= vel_x[31] ? (~vel_x + 32'd1) : vel_x;
			mvy_s1 <= vel_y[31] ? (~vel_y + 32'd1) : vel_y;
		end
	end

	// stage 2: squares and cross products
	logic        sx_s2, sy_s2, sa_s2, sb_s2;
	logic [31:0] mx_s2, my_s2;
	logic [63:0] sqx_s2, sqy_s2, ma_s2, mb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			sa_s2  <= svx_s1 ^ sy_s1;
			sb_s2  <= ~(svy_s1 ^ sx_s1);
			mx_s2  <= mx_s1;
			my_s2  <= my_s1;
			sqx_s2 <= 64'(mx_s1) * 64'(mx_s1);
			sqy_s2 <= 64'(my_s1) * 64'(my_s1);
			ma_s2  <= 64'(mvx_s1) * 64'(my_s1);
			mb_s2  <= 64'(mvy_s1) * 64'(mx_s1);
		end
	end

	// stage 3: r squared with floor substitution, cross term difference
	logic [63:0] r2_raw, r2_sel, md_c;
	logic        degen_c, sd_c;

	always_comb begin
		r2_raw  = sqx_s2 + sqy_s2;
		degen_c = (r2_raw < {32'd0, thresh_q});
		r2_sel  = degen_c ? {32'd0, floor_q} : r2_raw;
		if (r2_sel == 64'd0) begin
			r2_sel = 64'd1;
		end
		priority if (sa_s2 == sb_s2) begin
			md_c = ma_s2 + mb_s2;
			sd_c = sa_s2;
		end else if (ma_s2 >= mb_s2) begin
			md_c = ma_s2 - mb_s2;
			sd_c = sa_s2;
		end else begin
			md_c = mb_s2 - ma_s2;
			sd_c = sb_s2;
		end
	end

	logic        sx_s3, sy_s3, sd_s3, degen_s3;
	logic [31:0] mx_s3, my_s3;
	logic [63:0] r2_s3, md_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3    <= sx_s2;
			sy_s3    <= sy_s2;
			sd_s3    <= sd_c;
			degen_s3 <= degen_c;
			mx_s3    <= mx_s2;
			my_s3    <= my_s2;
			r2_s3    <= r2_sel;
			md_s3    <= md_c;
		end
	end

	// stage 4: partial products of position times difference
	logic        sx_s4, sy_s4, sd_s4, degen_s4;
	logic [31:0] mx_s4, my_s4;
	logic [63:0] r2_s4, pxl_s4, pxh_s4, pyl_s4, pyh_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s4    <= sx_s3;
			sy_s4    <= sy_s3;
			sd_s4    <= sd_s3;
			degen_s4 <= degen_s3;
			mx_s4    <= mx_s3;
			my_s4    <= my_s3;
			r2_s4    <= r2_s3;
			pxl_s4   <= 64'(mx_s3) * 64'(md_s3[31:0]);
			pxh_s4   <= 64'(mx_s3) * 64'(md_s3[63:32]);
			pyl_s4   <= 64'(my_s3) * 64'(md_s3[31:0]);
			pyh_s4   <= 64'(my_s3) * 64'(md_s3[63:32]);
		end
	end

	// stage 5: sum partial products, load the cell state
	logic [95:0] prod_x, prod_y;
	cell_st_t    ld_c;
	div_t        zero_lane;
	cell_st_t    st_s5;

	always_comb begin
		prod_x        = {32'd0, pxl_s4} + {pxh_s4, 32'd0};
		prod_y        = {32'd0, pyl_s4} + {pyh_s4, 32'd0};
		zero_lane     = '0;
		ld_c          = '0;
		ld_c.sx       = sx_s4;
		ld_c.sy       = sy_s4;
		ld_c.sd       = sd_s4;
		ld_c.degen    = degen_s4;
		ld_c.r2       = r2_s4;
		ld_c.sq.v     = r2_s4;
		ld_c.lane[LN_RANGE_DX]     = zero_lane;
		ld_c.lane[LN_RANGE_DX].num = {mx_s4, {(NUM_W-32){1'b0}}};
		ld_c.lane[LN_RANGE_DY]     = zero_lane;
		ld_c.lane[LN_RANGE_DY].num = {my_s4, {(NUM_W-32){1'b0}}};
		ld_c.lane[LN_BRG_DX]       = zero_lane;
		ld_c.lane[LN_BRG_DX].num   = {my_s4, {(NUM_W-32){1'b0}}};
		ld_c.lane[LN_BRG_DY]       = zero_lane;
		ld_c.lane[LN_BRG_DY].num   = {mx_s4, {(NUM_W-32){1'b0}}};
		ld_c.lane[LN_R1_DX]        = zero_lane;
		ld_c.lane[LN_R1_DX].num    = {prod_y, {(NUM_W-96){1'b0}}};
		ld_c.lane[LN_R1_DY]        = zero_lane;
		ld_c.lane[LN_R1_DY].num    = {prod_x, {(NUM_W-96){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s5 <= ld_c;
		end
	end

	assign v_out  = v_s5;
	assign st_out = st_s5;

endmodule

// ===== hw/rtl/rmj_cell.sv =====
// One cell of the divide and square-root chain: a digit of every active lane.
// Depends on rmj_pkg; the top level strings N_CELLS of these in a row.
`timescale 1ns / 1ps

module rmj_cell import rmj_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  logic             v_in,
	input  cell_st_t         st_in,
	output logic             v_out,
	output cell_st_t         st_out
);

	cell_st_t    nxt;
	logic [63:0] rr;
	div_t        r2x, r2y;
	logic        v_q;
	cell_st_t    st_q;

	// advance the lanes whose schedule covers this position
	always_comb begin
		nxt = st_in;
		rr  = {32'd0, st_in.sq.res};
		r2x = st_in.lane[LN_R2_DX];
		r2y = st_in.lane[LN_R2_DY];
		if (idx < SQRT_END) begin
			nxt.sq = sqrt_step(st_in.sq);
		end
		if (idx < BRG_END) begin
			nxt.lane[LN_BRG_DX] = div_step(st_in.lane[LN_BRG_DX], st_in.r2);
			nxt.lane[LN_BRG_DY] = div_step(st_in.lane[LN_BRG_DY], st_in.r2);
		end
		if (idx < RATE1_END) begin
			nxt.lane[LN_R1_DX] = div_step(st_in.lane[LN_R1_DX], st_in.r2);
			nxt.lane[LN_R1_DY] = div_step(st_in.lane[LN_R1_DY], st_in.r2);
		end
		if (idx >= SQRT_END && idx < RANGE_END) begin
			nxt.lane[LN_RANGE_DX] = div_step(st_in.lane[LN_RANGE_DX], rr);
			nxt.lane[LN_RANGE_DY] = div_step(st_in.lane[LN_RANGE_DY], rr);
		end
		if (idx >= RATE1_END) begin
			// first rate cell: take the clamped r2 quotient as the new numerator
			if (idx == RATE1_END) begin
				r2x.num = {q_clamp(st_in.lane[LN_R1_DX]), {(NUM_W-64){1'b0}}};
				r2y.num = {q_clamp(st_in.lane[LN_R1_DY]), {(NUM_W-64){1'b0}}};
			end
			nxt.lane[LN_R2_DX] = div_step(r2x, rr);
			nxt.lane[LN_R2_DY] = div_step(r2y, rr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign v_out  = v_q;
	assign st_out = st_q;

endmodule

// ===== hw/rtl/radar_measurement_jacobian_top.sv =====
// Top level of the radar measurement Jacobian block.
// Depends on rmj_pkg, rmj_front and rmj_cell.
`timescale 1ns / 1ps
//
// Input beats on s_* carry one state (x, y, vx, vy, signed Q16.16); each
// accepted beat yields exactly one result beat on m_* with the six
// nonconstant Jacobian entries and the degenerate and saturated flags.
// cfg_we writes register cfg_idx (0 threshold, 1 floor); write
// only while no beat is in flight.
// Throughput is one beat per cycle while the output queue is not full.
// The cell chain holds N_CELLS = 160 + FRAC_BITS cells, 176 at Q16.16,
// one digit per cell: 96 + FRAC_BITS for the r squared division of the
// rate terms, with the 32-digit square root running beside its first
// cells, then 64 more for the division by the range.
// Results land in a two-beat output queue. When the receiver stalls the
// chain keeps accepting until the queue is full, then the whole chain holds
// and s_tready drops; s_tready depends only on the queue fill.
// Reset clears all valid bits and the queue and restores threshold 43 and
// floor 1.
//

module radar_measurement_jacobian_top import rmj_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x [31:0], pos_y [63:32], vel_x [95:64], vel_y [127:96]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// range_dx [31:0], range_dy [63:32], bearing_dx [95:64],
	// bearing_dy [127:96], rate_dx [159:128], rate_dy [191:160]
	output logic [191:0] m_tdata,
	// degenerate [0], saturated [1]
	output logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [31:0]  cfg_data
);

	logic       en;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	result_t    mem_q [2];

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	logic     v_c  [N_CELLS+1];
	cell_st_t st_c [N_CELLS+1];

	rmj_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.pos_x    (s_tdata[31:0]),
		.pos_y    (s_tdata[63:32]),
		.vel_x    (s_tdata[95:64]),
		.vel_y    (s_tdata[127:96]),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_reg_e'(cfg_idx)),
		.cfg_data (cfg_data),
		.v_out    (v_c[0]),
		.st_out   (st_c[0])
	);

	// digit chain
	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		rmj_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (IDX_W'(g)),
			.v_in   (v_c[g]),
			.st_in  (st_c[g]),
			.v_out  (v_c[g+1]),
			.st_out (st_c[g+1])
		);
	end

	// clip each entry and gather the flags
	cell_st_t tail;
	sat_t     s_rx, s_ry, s_bx, s_by, s_tx, s_ty;
	result_t  res_c;

	always_comb begin
		tail = st_c[N_CELLS];
		s_rx = sat32(tail.sx, tail.lane[LN_RANGE_DX].q, tail.lane[LN_RANGE_DX].ovf);
		s_ry = sat32(tail.sy, tail.lane[LN_RANGE_DY].q, tail.lane[LN_RANGE_DY].ovf);
		s_bx = sat32(~tail.sy, tail.lane[LN_BRG_DX].q, tail.lane[LN_BRG_DX].ovf);
		s_by = sat32(tail.sx, tail.lane[LN_BRG_DY].q, tail.lane[LN_BRG_DY].ovf);
		s_tx = sat32(tail.sy ^ tail.sd, tail.lane[LN_R2_DX].q, tail.lane[LN_R2_DX].ovf);
		s_ty = sat32(tail.sx ^ ~tail.sd, tail.lane[LN_R2_DY].q, tail.lane[LN_R2_DY].ovf);
		res_c.range_dx   = s_rx.val;
		res_c.range_dy   = s_ry.val;
		res_c.bearing_dx = s_bx.val;
		res_c.bearing_dy = s_by.val;
		res_c.rate_dx    = s_tx.val;
		res_c.rate_dy    = s_ty.val;
		res_c.degenerate = tail.degen;
		res_c.saturated  = s_rx.clip | s_ry.clip | s_bx.clip | s_by.clip
			| s_tx.clip | s_ty.clip;
	end

	// output queue, two beats
	logic push, pop;
	assign push = en & v_c[N_CELLS];
	assign pop  = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= res_c;
		end
	end

	result_t head;
	assign head     = mem_q[rd_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {head.rate_dy, head.rate_dx, head.bearing_dy, head.bearing_dx,
		head.range_dy, head.range_dx};
	assign m_tuser  = {head.saturated, head.degenerate};

endmodule

// ===== hw/rtl/rmj_checker.sv =====
// Port-level checker for the radar Jacobian top level, bound to it below.
// Depends on radar_measurement_jacobian_top_macros.svh.
`timescale 1ns / 1ps
`include "radar_measurement_jacobian_top_macros.svh"

module rmj_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// a stalled result beat holds
	`RMJ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

	// input back-pressure only comes from results waiting in the queue
	`RMJ_ASSERT_NOW(a_bp_needs_result, !s_tready, m_tvalid, "s_tready low with no result pending")

	// a taken result frees queue space for the next cycle
	`RMJ_ASSERT_NEXT(a_drain_frees, m_tready, s_tready, "s_tready low after receiver was ready")

endmodule

bind radar_measurement_jacobian_top rmj_checker u_rmj_checker (.*);
